>>> sv/assert_macros.svh
// assertion helpers shared by the rtl files
// both expect aclk and aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define IEA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define IEA_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

>>> sv/iea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iea_pkg
// Shared types and constants for the I2C EEPROM access sequencer.
// ----------------------------------------------------------------------------
package iea_pkg;

    localparam int MEMORY_BYTES = 4096;
    localparam int PAGE_BYTES   = 32;
    // page size is a power of two, offset is the low address bits
    localparam int PAGE_W       = $clog2(PAGE_BYTES);
    localparam int PAGE_CNT_W   = $clog2(PAGE_BYTES + 1);

    localparam logic [6:0] DEV_ADDR_RESET = 7'd80;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [PAGE_CNT_W-1:0] page_cnt_t;
    typedef logic [FIFO_AW-1:0]    fifo_ptr_t;
    typedef logic [FIFO_AW:0]      fifo_cnt_t;

    // operation codes
    localparam logic [1:0] OP_READ       = 2'd0;
    localparam logic [1:0] OP_WRITE      = 2'd1;
    localparam logic [1:0] OP_HOST_BYTE  = 2'd2;
    localparam logic [1:0] OP_REPLY      = 2'd3;

    typedef enum logic [3:0] {
        ACT_START = 4'd0,
        ACT_WRITE = 4'd1,
        ACT_RACK  = 4'd2,
        ACT_RNACK = 4'd3,
        ACT_STOP  = 4'd4,
        ACT_WAIT  = 4'd5,
        ACT_HOST  = 4'd6,
        ACT_NEED  = 4'd7,
        ACT_OK    = 4'd8,
        ACT_ERR   = 4'd9
    } action_t;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_START,
        PH_SEL,
        PH_AHI,
        PH_ALO,
        PH_RSTART,
        PH_RSEL,
        PH_RDATA,
        PH_NEED,
        PH_WDATA,
        PH_WSTOP,
        PH_WAIT,
        PH_END
    } phase_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  byte_value;
        logic [15:0] wait_duration;
        logic        last;
    } result_t;

    // results produced by one transaction, first one goes out first
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_out_t;

    function automatic result_t mk_result(input action_t act, input logic [7:0] value,
                                          input logic [15:0] wait_ms);
        result_t r;
        r.action        = act;
        r.byte_value    = value;
        r.wait_duration = wait_ms;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

>>> sv/iea_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iea_ctrl
// Transfer state machine: turns one transaction into up to two bus results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iea_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [1:0]          operation,
    input  logic [15:0]         address,
    input  logic [15:0]         length,
    input  logic [15:0]         wait_time,
    input  logic [7:0]          data_byte,
    input  logic                acked,
    input  logic                timed_out,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata,
    output iea_pkg::step_out_t  step_o
);

    iea_pkg::phase_t    phase_reg, phase_next;
    logic               is_read_reg, is_read_next;
    logic [15:0]        cur_addr_reg, cur_addr_next;
    logic [15:0]        bytes_left_reg, bytes_left_next;
    iea_pkg::page_cnt_t page_left_reg, page_left_next;
    logic               timeout_reg, timeout_next;
    logic               failed_reg, failed_next;
    logic [15:0]        page_wait_reg, page_wait_next;
    logic [6:0]         dev_addr_reg;

    logic [7:0]         sel_byte;
    logic [16:0]        len_ext;
    logic [16:0]        addr_ext;
    logic [16:0]        mem_limit;
    logic               range_bad;
    logic [15:0]        bytes_dec;
    iea_pkg::page_cnt_t page_dec;
    iea_pkg::result_t   res0, res1;
    logic [1:0]         n_res;

    function automatic iea_pkg::page_cnt_t page_room(input logic [15:0] addr,
                                                     input logic [15:0] left);
        iea_pkg::page_cnt_t room;
        room = iea_pkg::page_cnt_t'(iea_pkg::PAGE_BYTES)
             - iea_pkg::page_cnt_t'(addr[iea_pkg::PAGE_W-1:0]);
        if (left < 16'(room)) begin
            return left[iea_pkg::PAGE_CNT_W-1:0];
        end
        return room;
    endfunction

    function automatic iea_pkg::action_t read_act(input logic [15:0] left);
        return (left > 16'd1) ? iea_pkg::ACT_RACK : iea_pkg::ACT_RNACK;
    endfunction

    assign sel_byte  = {dev_addr_reg, 1'b0};
    assign len_ext   = {1'b0, length};
    assign addr_ext  = {1'b0, address};
    assign mem_limit = 17'(iea_pkg::MEMORY_BYTES);
    assign range_bad = (length == 16'd0) || (len_ext > mem_limit)
                    || (addr_ext > mem_limit - len_ext);
    assign bytes_dec = bytes_left_reg - 16'd1;
    assign page_dec  = page_left_reg - iea_pkg::page_cnt_t'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= iea_pkg::PH_IDLE;
            is_read_reg    <= 1'b0;
            cur_addr_reg   <= '0;
            bytes_left_reg <= '0;
            page_left_reg  <= '0;
            timeout_reg    <= 1'b0;
            failed_reg     <= 1'b0;
            page_wait_reg  <= '0;
            dev_addr_reg   <= iea_pkg::DEV_ADDR_RESET;
        end else begin
            if (cfg_we) begin
                dev_addr_reg <= cfg_wdata;
            end
            if (fire) begin
                phase_reg      <= phase_next;
                is_read_reg    <= is_read_next;
                cur_addr_reg   <= cur_addr_next;
                bytes_left_reg <= bytes_left_next;
                page_left_reg  <= page_left_next;
                timeout_reg    <= timeout_next;
                failed_reg     <= failed_next;
                page_wait_reg  <= page_wait_next;
            end
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        is_read_next    = is_read_reg;
        cur_addr_next   = cur_addr_reg;
        bytes_left_next = bytes_left_reg;
        page_left_next  = page_left_reg;
        timeout_next    = timeout_reg;
        failed_next     = failed_reg;
        page_wait_next  = page_wait_reg;
        res0            = '0;
        res1            = '0;
        n_res           = 2'd0;

        if (phase_reg == iea_pkg::PH_IDLE) begin
            if (operation == iea_pkg::OP_READ) begin
                n_res = 2'd1;
                if (range_bad) begin
                    res0 = iea_pkg::mk_result(iea_pkg::ACT_ERR, 8'd0, 16'd0);
                end else begin
                    is_read_next    = 1'b1;
                    cur_addr_next   = address;
                    bytes_left_next = length;
                    timeout_next    = 1'b0;
                    failed_next     = 1'b0;
                    phase_next      = iea_pkg::PH_START;
                    res0 = iea_pkg::mk_result(iea_pkg::ACT_START, 8'd0, 16'd0);
                end
            end else if (operation == iea_pkg::OP_WRITE) begin
                n_res = 2'd1;
                if (length == 16'd0) begin
                    res0 = iea_pkg::mk_result(iea_pkg::ACT_OK, 8'd0, 16'd0);
                end else begin
                    is_read_next    = 1'b0;
                    cur_addr_next   = address;
                    bytes_left_next = length;
                    page_wait_next  = wait_time;
                    timeout_next    = 1'b0;
                    failed_next     = 1'b0;
                    page_left_next  = page_room(address, length);
                    phase_next      = iea_pkg::PH_START;
                    res0 = iea_pkg::mk_result(iea_pkg::ACT_START, 8'd0, 16'd0);
                end
            end
        end else if (phase_reg == iea_pkg::PH_NEED) begin
            if (operation == iea_pkg::OP_HOST_BYTE) begin
                n_res      = 2'd1;
                phase_next = iea_pkg::PH_WDATA;
                res0 = iea_pkg::mk_result(iea_pkg::ACT_WRITE, data_byte, 16'd0);
            end
        end else if (operation == iea_pkg::OP_REPLY) begin
            // timeouts only count against reads
            timeout_next = timeout_reg | (is_read_reg & timed_out);
            n_res        = 2'd1;
            case (phase_reg)
                iea_pkg::PH_START: begin
                    phase_next = iea_pkg::PH_SEL;
                    res0 = iea_pkg::mk_result(iea_pkg::ACT_WRITE, sel_byte, 16'd0);
                end
                iea_pkg::PH_SEL: begin
                    if (!acked) begin
                        failed_next = 1'b1;
                        phase_next  = iea_pkg::PH_END;
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_STOP, 8'd0, 16'd0);
                    end else begin
                        phase_next = iea_pkg::PH_AHI;
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_WRITE, cur_addr_reg[15:8],
                                                  16'd0);
                    end
                end
                iea_pkg::PH_AHI: begin
                    if (!acked) begin
                        failed_next = 1'b1;
                        phase_next  = iea_pkg::PH_END;
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_STOP, 8'd0, 16'd0);
                    end else begin
                        phase_next = iea_pkg::PH_ALO;
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_WRITE, cur_addr_reg[7:0],
                                                  16'd0);
                    end
                end
                iea_pkg::PH_ALO: begin
                    if (!acked) begin
                        failed_next = 1'b1;
                        phase_next  = iea_pkg::PH_END;
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_STOP, 8'd0, 16'd0);
                    end else if (is_read_reg) begin
                        phase_next = iea_pkg::PH_RSTART;
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_START, 8'd0, 16'd0);
                    end else begin
                        phase_next = iea_pkg::PH_NEED;
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_NEED, 8'd0, 16'd0);
                    end
                end
                iea_pkg::PH_RSTART: begin
                    phase_next = iea_pkg::PH_RSEL;
                    res0 = iea_pkg::mk_result(iea_pkg::ACT_WRITE, sel_byte | 8'd1, 16'd0);
                end
                iea_pkg::PH_RSEL: begin
                    if (!acked) begin
                        failed_next = 1'b1;
                        phase_next  = iea_pkg::PH_END;
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_STOP, 8'd0, 16'd0);
                    end else begin
                        phase_next = iea_pkg::PH_RDATA;
                        res0 = iea_pkg::mk_result(read_act(bytes_left_reg), 8'd0, 16'd0);
                    end
                end
                iea_pkg::PH_RDATA: begin
                    // hand the byte to the host, then either read on or stop
                    res0            = iea_pkg::mk_result(iea_pkg::ACT_HOST, data_byte, 16'd0);
                    bytes_left_next = bytes_dec;
                    n_res           = 2'd2;
                    if (bytes_dec != 16'd0) begin
                        res1 = iea_pkg::mk_result(read_act(bytes_dec), 8'd0, 16'd0);
                    end else begin
                        phase_next = iea_pkg::PH_END;
                        res1 = iea_pkg::mk_result(iea_pkg::ACT_STOP, 8'd0, 16'd0);
                    end
                end
                iea_pkg::PH_WDATA: begin
                    if (!acked) begin
                        failed_next = 1'b1;
                        phase_next  = iea_pkg::PH_END;
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_STOP, 8'd0, 16'd0);
                    end else begin
                        cur_addr_next   = cur_addr_reg + 16'd1;
                        bytes_left_next = bytes_dec;
                        page_left_next  = page_dec;
                        if (page_dec != '0) begin
                            phase_next = iea_pkg::PH_NEED;
                            res0 = iea_pkg::mk_result(iea_pkg::ACT_NEED, 8'd0, 16'd0);
                        end else begin
                            phase_next = iea_pkg::PH_WSTOP;
                            res0 = iea_pkg::mk_result(iea_pkg::ACT_STOP, 8'd0, 16'd0);
                        end
                    end
                end
                iea_pkg::PH_WSTOP: begin
                    phase_next = iea_pkg::PH_WAIT;
                    res0 = iea_pkg::mk_result(iea_pkg::ACT_WAIT, 8'd0, page_wait_reg);
                end
                iea_pkg::PH_WAIT: begin
                    if (bytes_left_reg != 16'd0) begin
                        page_left_next = page_room(cur_addr_reg, bytes_left_reg);
                        phase_next     = iea_pkg::PH_START;
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_START, 8'd0, 16'd0);
                    end else begin
                        phase_next = iea_pkg::PH_IDLE;
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_OK, 8'd0, 16'd0);
                    end
                end
                iea_pkg::PH_END: begin
                    phase_next = iea_pkg::PH_IDLE;
                    if (failed_reg || (is_read_reg && timeout_next)) begin
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_ERR, 8'd0, 16'd0);
                    end else begin
                        res0 = iea_pkg::mk_result(iea_pkg::ACT_OK, 8'd0, 16'd0);
                    end
                end
                default: begin
                    phase_next = iea_pkg::PH_IDLE;
                    n_res      = 2'd0;
                end
            endcase
        end

        if (n_res == 2'd2) begin
            res1.last = 1'b1;
        end else if (n_res == 2'd1) begin
            res0.last = 1'b1;
        end
    end

    assign step_o.count  = n_res;
    assign step_o.first  = res0;
    assign step_o.second = res1;

    `IEA_ASSERT(a_pair_only_in_read_data, (fire && step_o.count == 2'd2) |-> (phase_reg == iea_pkg::PH_RDATA && step_o.first.action == iea_pkg::ACT_HOST), "two results outside read data phase")
    `IEA_ASSERT(a_page_count_live, (phase_reg == iea_pkg::PH_NEED || phase_reg == iea_pkg::PH_WDATA) |-> (page_left_reg != '0 && !is_read_reg), "page count empty during write data")
    `IEA_ASSERT(a_read_bytes_live, (phase_reg == iea_pkg::PH_RDATA) |-> (bytes_left_reg != 16'd0 && is_read_reg), "read data phase with no bytes left")

endmodule

>>> sv/iea_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iea_out_fifo
// Small result queue: takes up to two results per cycle, hands out one per pop.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iea_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         push_cnt,
    input  iea_pkg::result_t   push0,
    input  iea_pkg::result_t   push1,
    input  logic               pop,
    output iea_pkg::result_t   head,
    output logic               not_empty,
    output logic               room_two
);

    iea_pkg::result_t   entry_reg [iea_pkg::FIFO_DEPTH];
    iea_pkg::fifo_ptr_t wr_ptr_reg, wr_ptr_next;
    iea_pkg::fifo_ptr_t rd_ptr_reg, rd_ptr_next;
    iea_pkg::fifo_cnt_t count_reg, count_next;
    iea_pkg::fifo_ptr_t wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + iea_pkg::fifo_ptr_t'(1);
    assign wr_ptr_next  = wr_ptr_reg + iea_pkg::fifo_ptr_t'(push_cnt);
    assign rd_ptr_next  = rd_ptr_reg + iea_pkg::fifo_ptr_t'(pop);
    assign count_next   = count_reg + iea_pkg::fifo_cnt_t'(push_cnt)
                        - iea_pkg::fifo_cnt_t'(pop);

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room_two  = (count_reg <= iea_pkg::fifo_cnt_t'(iea_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push1;
        end
    end

    `IEA_ASSERT_NEVER(a_no_overflow, (count_reg > iea_pkg::fifo_cnt_t'(iea_pkg::FIFO_DEPTH)), "result queue overflow")
    `IEA_ASSERT_NEVER(a_push_fits, (push_cnt != 2'd0 && !room_two), "results pushed without room")

endmodule

>>> sv/i2c_eeprom_access_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_access_sequencer
// Breaks random reads and paged writes of a two-byte-address I2C EEPROM into
// bus primitives, one per bus reply, and reports completion to the host.
//
//   channel   prefix  direction  carries
//   command   s_      in         host commands, host bytes, bus replies
//   result    m_      out        bus primitives, host data, status
//   config    cfg_    in         seven-bit device address, no wait
//
// one transaction per cycle while s_ready is high, decoded in the cycle it is
// accepted; its one or two results enter a four-entry result queue and leave
// one per cycle while m_ready is high; s_ready drops at under two free entries
// reset is synchronous, clears the transfer state and empties the queue
// results appear on m_ in the cycle after the transaction at the earliest
// ----------------------------------------------------------------------------

module i2c_eeprom_access_sequencer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_address,
    input  logic [15:0] s_length,
    input  logic [15:0] s_wait_time,
    input  logic [7:0]  s_data_byte,
    input  logic        s_acked,
    input  logic        s_timed_out,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_action,
    output logic [7:0]  m_byte_value,
    output logic [15:0] m_wait_duration,
    output logic        m_last,

    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    logic               s_fire;
    logic               m_fire;
    logic               room_two;
    iea_pkg::step_out_t step;
    iea_pkg::result_t   head;

    assign s_ready = room_two;
    assign s_fire  = s_valid & room_two;
    assign m_fire  = m_valid & m_ready;

    iea_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (s_fire),
        .operation (s_operation),
        .address   (s_address),
        .length    (s_length),
        .wait_time (s_wait_time),
        .data_byte (s_data_byte),
        .acked     (s_acked),
        .timed_out (s_timed_out),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step_o    (step)
    );

    iea_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (s_fire ? step.count : 2'd0),
        .push0     (step.first),
        .push1     (step.second),
        .pop       (m_fire),
        .head      (head),
        .not_empty (m_valid),
        .room_two  (room_two)
    );

    assign m_action        = head.action;
    assign m_byte_value    = head.byte_value;
    assign m_wait_duration = head.wait_duration;
    assign m_last          = head.last;

endmodule
